// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl, used by dca_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define DCA_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every rising clock edge
`define DCA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dca_pkg.sv =====
`timescale 1ns / 1ps
package dca_pkg;

  localparam logic [1:0] OP_LOAD_P = 2'd0;
  localparam logic [1:0] OP_LOAD_Q = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_DROP  = 2'd2;

  localparam int COST_W = 23;
  localparam logic [COST_W-1:0] COST_MAX = 23'h7FFFFF;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    CMD_LOAD_P,
    CMD_LOAD_Q,
    CMD_START
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL_RD,
    ST_FILL_SUB,
    ST_FILL_MUL,
    ST_FILL_SQ,
    ST_FILL_WAIT,
    ST_FILL_WR,
    ST_TB_PUT,
    ST_TB_UP,
    ST_TB_DG,
    ST_TB_LF,
    ST_TB_DEC,
    ST_EM_RD,
    ST_EM_SHOW
  } eng_state_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ===== rtl/dca_front.sv =====
`timescale 1ns / 1ps
module dca_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_operation,
  input  logic [COORD_BITS-1:0]  in_x_coord,
  input  logic [COORD_BITS-1:0]  in_y_coord,
  output dca_pkg::q_head_t       head,
  output logic [COORD_BITS-1:0]  head_x,
  output logic [COORD_BITS-1:0]  head_y,
  input  logic                   pop
);
  import dca_pkg::*;

  cmd_t                  cmd_q [QDEPTH];
  logic [COORD_BITS-1:0] x_q   [QDEPTH];
  logic [COORD_BITS-1:0] y_q   [QDEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]     count_r;
  logic                  push, keep;
  cmd_t                  cls;

  // classify; unknown operations are taken and dropped here
  always_comb begin
    keep = 1'b1;
    cls  = CMD_START;
    unique case (in_operation)
      OP_LOAD_P: cls = CMD_LOAD_P;
      OP_LOAD_Q: cls = CMD_LOAD_Q;
      OP_START:  cls = CMD_START;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall = (count_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall && keep;

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_ptr_r] <= cls;
      x_q[wr_ptr_r]   <= in_x_coord;
      y_q[wr_ptr_r]   <= in_y_coord;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = cmd_q[rd_ptr_r];
  assign head_x     = x_q[rd_ptr_r];
  assign head_y     = y_q[rd_ptr_r];

endmodule

// ===== rtl/dca_sqrt.sv =====
`timescale 1ns / 1ps
module dca_sqrt #(
  parameter int IN_W = 36
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [IN_W-1:0]     operand,
  output logic                done,
  output logic [IN_W/2-1:0]   root
);
  localparam int ROOT_W = IN_W / 2;
  localparam int CW     = $clog2(ROOT_W + 1);

  logic [IN_W-1:0]   n_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CW-1:0]     cnt_r;
  logic              run_r, done_r;
  logic [ROOT_W+2:0] rem_sh, trial, rem_sub;
  logic              ge;

  // one result bit per cycle, restoring form
  assign rem_sh  = {rem_r, n_r[IN_W-1:IN_W-2]};
  assign trial   = {1'b0, root_r, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= operand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (run_r) begin
      n_r    <= n_r << 2;
      rem_r  <= ge ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(ROOT_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/dca_engine.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dca_engine #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dca_pkg::q_head_t              head,
  input  logic [COORD_BITS-1:0]         head_x,
  input  logic [COORD_BITS-1:0]         head_y,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [$clog2(MAX_POINTS)-1:0] out_step_i,
  output logic [$clog2(MAX_POINTS)-1:0] out_step_j,
  output logic [dca_pkg::COST_W-1:0]    out_total_cost,
  output logic [1:0]                    out_status,
  output logic                          out_last
);
  import dca_pkg::*;

  localparam int IDX_W    = $clog2(MAX_POINTS);
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int CELLS    = 1 << (2 * IDX_W);
  localparam int PATH_LEN = 2 * MAX_POINTS - 1;
  localparam int PW       = $clog2(PATH_LEN);
  localparam int PN_W     = $clog2(PATH_LEN + 1);
  localparam int CB       = COORD_BITS;
  localparam int PT_W     = 2 * CB;
  localparam int DW       = CB + 1;
  localparam int SQ_W     = 2 * DW;
  localparam int SUM_W    = 2 * DW + 2;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int CMP_W    = (ROOT_W > COST_W) ? ROOT_W : COST_W;

  logic [PT_W-1:0]    p_mem    [MAX_POINTS];
  logic [PT_W-1:0]    q_mem    [MAX_POINTS];
  logic [COST_W-1:0]  cost_mem [CELLS];
  logic [2*IDX_W-1:0] path_mem [PATH_LEN];

  eng_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   p_cnt_r, q_cnt_r, m1_r, m2_r;
  logic               ovf_r;
  logic [IDX_W-1:0]   i_r, j_r;
  logic [1:0]         status_r;
  logic [COST_W-1:0]  total_r, up_r, diag_r, left_r, cost_rd_r;
  logic [PT_W-1:0]    p_rd_r, q_rd_r;
  logic [2*IDX_W-1:0] path_rd_r;
  logic [DW-1:0]      dx_r, dy_r;
  logic [SQ_W-1:0]    sx_r, sy_r;
  logic [PN_W-1:0]    n_r;
  logic [PW-1:0]      ptr_r;

  logic               sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]  sqrt_root;
  logic               cost_we, path_we, out_fire, empty_run;
  logic [2*IDX_W-1:0] cost_ra, path_wd;
  logic [PW-1:0]      path_wa;
  logic               last_j, last_i;

  logic signed [DW-1:0] px, py, qx, qy, dxs, dys;
  logic [COST_W-1:0]    step_d, mn_ud, mn3, base, newc;
  logic [COST_W:0]      sum_c;

  dca_sqrt #(.IN_W(SUM_W)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sqrt_start),
    .operand (SUM_W'(sx_r) + SUM_W'(sy_r)),
    .done    (sqrt_done),
    .root    (sqrt_root)
  );

  assign empty_run = (p_cnt_r == '0) || (q_cnt_r == '0);
  assign last_j    = (CNT_W'(j_r) == m2_r - CNT_W'(1));
  assign last_i    = (CNT_W'(i_r) == m1_r - CNT_W'(1));
  assign out_fire  = out_valid && !out_stall;

  // step cost: |p - q| then squares, root in the square root unit
  assign px  = {p_rd_r[PT_W-1], p_rd_r[PT_W-1:CB]};
  assign py  = {p_rd_r[CB-1], p_rd_r[CB-1:0]};
  assign qx  = {q_rd_r[PT_W-1], q_rd_r[PT_W-1:CB]};
  assign qy  = {q_rd_r[CB-1], q_rd_r[CB-1:0]};
  assign dxs = px - qx;
  assign dys = py - qy;

  assign step_d = (CMP_W'(sqrt_root) > CMP_W'(COST_MAX)) ? COST_MAX
                : COST_W'(sqrt_root);
  assign mn_ud  = (up_r < diag_r) ? up_r : diag_r;
  assign mn3    = (left_r < mn_ud) ? left_r : mn_ud;

  always_comb begin
    priority if (i_r == '0 && j_r == '0) base = '0;
    else if (i_r == '0)                  base = left_r;
    else if (j_r == '0)                  base = up_r;
    else                                 base = mn3;
  end

  assign sum_c = {1'b0, base} + {1'b0, step_d};
  assign newc  = (sum_c > {1'b0, COST_MAX}) ? COST_MAX : sum_c[COST_W-1:0];

  always_comb begin
    unique case (state_r)
      ST_TB_DG: cost_ra = {i_r - 1'b1, j_r - 1'b1};
      ST_TB_LF: cost_ra = {i_r, j_r - 1'b1};
      default:  cost_ra = {i_r - 1'b1, j_r};
    endcase
  end

  // the empty-run pair always lands in the first entry
  assign path_wd = (state_r == ST_IDLE) ? '0 : {i_r, j_r};
  assign path_wa = (state_r == ST_IDLE) ? '0 : n_r[PW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (head.valid && head.cmd == CMD_START)
          state_nxt = empty_run ? ST_EM_RD : ST_FILL_RD;
      ST_FILL_RD:   state_nxt = ST_FILL_SUB;
      ST_FILL_SUB:  state_nxt = ST_FILL_MUL;
      ST_FILL_MUL:  state_nxt = ST_FILL_SQ;
      ST_FILL_SQ:   state_nxt = ST_FILL_WAIT;
      ST_FILL_WAIT: if (sqrt_done) state_nxt = ST_FILL_WR;
      ST_FILL_WR:   state_nxt = (last_i && last_j) ? ST_TB_PUT : ST_FILL_RD;
      ST_TB_PUT: begin
        priority if (i_r == '0 && j_r == '0) state_nxt = ST_EM_RD;
        else if (i_r != '0 && j_r != '0)     state_nxt = ST_TB_UP;
        else                                 state_nxt = ST_TB_PUT;
      end
      ST_TB_UP:     state_nxt = ST_TB_DG;
      ST_TB_DG:     state_nxt = ST_TB_LF;
      ST_TB_LF:     state_nxt = ST_TB_DEC;
      ST_TB_DEC:    state_nxt = ST_TB_PUT;
      ST_EM_RD:     state_nxt = ST_EM_SHOW;
      ST_EM_SHOW:
        if (out_fire) state_nxt = (ptr_r == '0) ? ST_IDLE : ST_EM_RD;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    pop        = 1'b0;
    cost_we    = 1'b0;
    path_we    = 1'b0;
    sqrt_start = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        pop     = head.valid;
        path_we = head.valid && head.cmd == CMD_START && empty_run;
      end
      ST_FILL_SQ: sqrt_start = 1'b1;
      ST_FILL_WR: cost_we    = 1'b1;
      ST_TB_PUT:  path_we    = 1'b1;
      ST_EM_SHOW: out_valid  = 1'b1;
      default: ;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && head.valid && head.cmd == CMD_LOAD_P &&
        p_cnt_r != CNT_W'(MAX_POINTS))
      p_mem[p_cnt_r[IDX_W-1:0]] <= {head_x, head_y};
    if (state_r == ST_IDLE && head.valid && head.cmd == CMD_LOAD_Q &&
        q_cnt_r != CNT_W'(MAX_POINTS))
      q_mem[q_cnt_r[IDX_W-1:0]] <= {head_x, head_y};
    p_rd_r <= p_mem[i_r];
    q_rd_r <= q_mem[j_r];
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[{i_r, j_r}] <= newc;
    cost_rd_r <= cost_mem[cost_ra];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_wa] <= path_wd;
    path_rd_r <= path_mem[ptr_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE:
        if (head.valid && head.cmd == CMD_START) begin
          m1_r     <= p_cnt_r;
          m2_r     <= q_cnt_r;
          i_r      <= '0;
          j_r      <= '0;
          ptr_r    <= '0;
          total_r  <= '0;
          status_r <= empty_run ? STAT_EMPTY : (ovf_r ? STAT_DROP : STAT_OK);
        end
      ST_FILL_SUB: begin
        dx_r <= dxs[DW-1] ? DW'(-dxs) : DW'(dxs);
        dy_r <= dys[DW-1] ? DW'(-dys) : DW'(dys);
        up_r <= cost_rd_r;
      end
      ST_FILL_MUL: begin
        sx_r <= dx_r * dx_r;
        sy_r <= dy_r * dy_r;
      end
      ST_FILL_WR: begin
        left_r <= newc;
        diag_r <= up_r;
        if (last_j) begin
          if (last_i) begin
            total_r <= newc;
            i_r     <= i_r;
            j_r     <= j_r;
          end else begin
            i_r <= i_r + 1'b1;
            j_r <= '0;
          end
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
      ST_TB_PUT: begin
        priority if (i_r == '0 && j_r == '0) ptr_r <= n_r[PW-1:0];
        else if (i_r != '0 && j_r == '0)     i_r <= i_r - 1'b1;
        else if (i_r == '0)                  j_r <= j_r - 1'b1;
        else                                 ptr_r <= ptr_r;
      end
      ST_TB_DG: up_r   <= cost_rd_r;
      ST_TB_LF: diag_r <= cost_rd_r;
      ST_TB_DEC: begin
        // ties: upper first, then left, then diagonal
        priority if (up_r <= diag_r && up_r <= cost_rd_r) begin
          i_r <= i_r - 1'b1;
        end else if (cost_rd_r <= diag_r && cost_rd_r <= up_r) begin
          j_r <= j_r - 1'b1;
        end else begin
          i_r <= i_r - 1'b1;
          j_r <= j_r - 1'b1;
        end
      end
      ST_EM_SHOW: if (out_fire && ptr_r != '0) ptr_r <= ptr_r - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      p_cnt_r <= '0;
      q_cnt_r <= '0;
      ovf_r   <= 1'b0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && head.valid) begin
        unique case (head.cmd)
          CMD_LOAD_P:
            if (p_cnt_r != CNT_W'(MAX_POINTS)) p_cnt_r <= p_cnt_r + 1'b1;
            else                               ovf_r   <= 1'b1;
          CMD_LOAD_Q:
            if (q_cnt_r != CNT_W'(MAX_POINTS)) q_cnt_r <= q_cnt_r + 1'b1;
            else                               ovf_r   <= 1'b1;
          CMD_START: begin
            p_cnt_r <= '0;
            q_cnt_r <= '0;
            ovf_r   <= 1'b0;
            n_r     <= '0;
          end
          default: ;
        endcase
      end else if (path_we) begin
        n_r <= n_r + 1'b1;
      end
    end
  end

  assign out_step_i     = path_rd_r[2*IDX_W-1:IDX_W];
  assign out_step_j     = path_rd_r[IDX_W-1:0];
  assign out_total_cost = total_r;
  assign out_status     = status_r;
  assign out_last       = (ptr_r == '0);

  `DCA_ASSERT(a_pop_idle, clk, rst_n, pop |-> head.valid && state_r == ST_IDLE, "pop outside idle")
  `DCA_ASSERT(a_sqrt_done, clk, rst_n, sqrt_done |-> state_r == ST_FILL_WAIT, "root outside wait")
  `DCA_ASSERT(a_path_len, clk, rst_n, n_r <= PN_W'(PATH_LEN), "path store overrun")

endmodule

// ===== rtl/dtw_curve_alignment.sv =====
`timescale 1ns / 1ps
// Dynamic time warping of two 2-D curves with path traceback. Load items
// (operation 0 for P, 1 for Q) go through a four-item queue and are taken
// by the engine while it is idle; operation 3 is dropped at the front. A
// start item fills the cost table one cell at a time, each cell waiting on
// the bit-serial square root unit. The traceback then reads the upper,
// diagonal and left costs of each path pair away from the table edges in
// turn through the single cost table read port, and each result is read
// in ST_EM_RD and held in ST_EM_SHOW until it is taken. Results carry the
// path from (0,0) forward, the total cost, the status and a last mark;
// loads keep queueing while a run is in progress.
module dtw_curve_alignment #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [COORD_BITS-1:0]         in_x_coord,
  input  logic [COORD_BITS-1:0]         in_y_coord,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [$clog2(MAX_POINTS)-1:0] out_step_i,
  output logic [$clog2(MAX_POINTS)-1:0] out_step_j,
  output logic [dca_pkg::COST_W-1:0]    out_total_cost,
  output logic [1:0]                    out_status,
  output logic                          out_last
);
  import dca_pkg::*;

  q_head_t               head;
  logic [COORD_BITS-1:0] head_x, head_y;
  logic                  pop;

  dca_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_x_coord   (in_x_coord),
    .in_y_coord   (in_y_coord),
    .head         (head),
    .head_x       (head_x),
    .head_y       (head_y),
    .pop          (pop)
  );

  dca_engine #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .head_x         (head_x),
    .head_y         (head_y),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_step_i     (out_step_i),
    .out_step_j     (out_step_j),
    .out_total_cost (out_total_cost),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

// ===== tb/sv/dtw_curve_alignment_test.sv =====
`timescale 1ns / 1ps
module dtw_curve_alignment_test;
  import dca_pkg::*;

  localparam int NPTS = 32;
  localparam int CW = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [22:0] COST_SAT = 23'h7FFFFF;

  typedef struct packed {
    logic [4:0]  i;
    logic [4:0]  j;
    logic [22:0] total;
    logic [1:0]  status;
    logic        last;
  } pair_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    bit          has_fixed;
    pair_t       fixed;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_operation = OP_LOAD_P;
  logic [CW-1:0] in_x_coord = '0;
  logic [CW-1:0] in_y_coord = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [4:0] out_step_i;
  logic [4:0] out_step_j;
  logic [22:0] out_total_cost;
  logic [1:0] out_status;
  logic out_last;

  dtw_curve_alignment dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic signed [15:0] px [NPTS], py [NPTS], qx [NPTS], qy [NPTS];
  int unsigned p_held = 0, q_held = 0;
  bit dropped = 0;
  logic [22:0] costs [NPTS][NPTS];
  pair_t path_q [$];
  int errors = 0;

  int send_idle = 0, recv_idle = 0;
  bit long_hold = 0;

  function automatic logic [22:0] point_distance(int a, int b);
    longint unsigned dx, dy, s, root, bitv;
    dx = (px[a] >= qx[b]) ? longint'(px[a]) - qx[b] : longint'(qx[b]) - px[a];
    dy = (py[a] >= qy[b]) ? longint'(py[a]) - qy[b] : longint'(qy[b]) - py[a];
    s = dx * dx + dy * dy;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return (root > COST_SAT) ? COST_SAT : root[22:0];
  endfunction

  function automatic logic [22:0] add_sat(logic [22:0] a, logic [22:0] b);
    logic [23:0] s;
    s = a + b;
    return (s > COST_SAT) ? COST_SAT : s[22:0];
  endfunction

  function automatic logic [22:0] min3(logic [22:0] a, logic [22:0] b, logic [22:0] c);
    logic [22:0] t;
    t = (a < b) ? a : b;
    return (c < t) ? c : t;
  endfunction

  task automatic predict_alignment();
    int ti [$], tj [$];
    int i, j, n;
    logic [22:0] base, up, dg, lf, total;
    logic [1:0] st;
    pair_t r;
    if (p_held == 0 || q_held == 0) begin
      r = '{i: 0, j: 0, total: 0, status: STAT_EMPTY, last: 1};
      path_q = {path_q, r};
    end else begin
      st = dropped ? STAT_DROP : STAT_OK;
      for (i = 0; i < p_held; i++)
        for (j = 0; j < q_held; j++) begin
          if (i == 0 && j == 0) base = 0;
          else if (i == 0) base = costs[0][j-1];
          else if (j == 0) base = costs[i-1][0];
          else base = min3(costs[i-1][j], costs[i-1][j-1], costs[i][j-1]);
          costs[i][j] = add_sat(base, point_distance(i, j));
        end
      total = costs[p_held-1][q_held-1];
      i = p_held - 1;
      j = q_held - 1;
      while (i > 0 && j > 0) begin
        up = costs[i-1][j]; dg = costs[i-1][j-1]; lf = costs[i][j-1];
        ti.push_front(i); tj.push_front(j);
        if (up <= dg && up <= lf) i--;
        else if (lf <= dg && lf <= up) j--;
        else begin i--; j--; end
      end
      while (i > 0) begin ti.push_front(i); tj.push_front(j); i--; end
      while (j > 0) begin ti.push_front(i); tj.push_front(j); j--; end
      ti.push_front(0); tj.push_front(0);
      n = ti.size();
      for (int k = 0; k < n; k++) begin
        r = '{i: 5'(ti[k]), j: 5'(tj[k]), total: total, status: st, last: k == n - 1};
        path_q = {path_q, r};
      end
    end
    p_held = 0;
    q_held = 0;
    dropped = 0;
  endtask

  task automatic predict_item(logic [1:0] op, logic [15:0] x, logic [15:0] y);
    if (op == OP_LOAD_P) begin
      if (p_held < NPTS) begin px[p_held] = x; py[p_held] = y; p_held++; end
      else dropped = 1;
    end else if (op == OP_LOAD_Q) begin
      if (q_held < NPTS) begin qx[q_held] = x; qy[q_held] = y; q_held++; end
      else dropped = 1;
    end else if (op == OP_START) begin
      predict_alignment();
    end
  endtask

  // drop valid for one cycle
  task automatic release_input();
    in_valid <= 0;
    @(posedge clk);
  endtask

  // drive one item; predictions happen at acceptance
  task automatic send_item(logic [1:0] op, logic [15:0] x, logic [15:0] y);
    while (send_idle > 0 && $urandom_range(99) < send_idle) release_input();
    in_valid <= 1;
    in_operation <= op;
    in_x_coord <= x;
    in_y_coord <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(op, x, y);
  endtask

  task automatic wait_drained();
    release_input();
    while (path_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (long_hold) out_stall <= 1;
    else out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (path_q.size() == 0) begin
        $error("result with no expectation: i=%0d j=%0d", out_step_i, out_step_j);
        errors++;
      end else begin
        want = path_q.pop_front();
        if (out_step_i !== want.i) begin
          $error("step_i expected %0d got %0d", want.i, out_step_i); errors++;
        end
        if (out_step_j !== want.j) begin
          $error("step_j expected %0d got %0d", want.j, out_step_j); errors++;
        end
        if (out_total_cost !== want.total) begin
          $error("total_cost expected %0d got %0d", want.total, out_total_cost); errors++;
        end
        if (out_status !== want.status) begin
          $error("status expected %0d got %0d", want.status, out_status); errors++;
        end
        if (out_last !== want.last) begin
          $error("last expected %0d got %0d", want.last, out_last); errors++;
        end
      end
    end
  end

  task automatic random_curves(int np, int nq, bit wide);
    logic [1:0] order [$];
    for (int k = 0; k < np; k++) order = {order, OP_LOAD_P};
    for (int k = 0; k < nq; k++) order = {order, OP_LOAD_Q};
    order.shuffle();
    foreach (order[k]) begin
      if ($urandom_range(19) == 0) send_item(OP_UNUSED, 16'($urandom), 16'($urandom));
      if (wide) send_item(order[k], 16'($urandom), 16'($urandom));
      else send_item(order[k], 16'($urandom_range(1023) - 512),
                     16'($urandom_range(1023) - 512));
    end
    send_item(OP_START, 16'($urandom), 16'($urandom));
  endtask

  stim_row_t rows [$];

  task automatic add_row(logic [1:0] op, logic [15:0] x, logic [15:0] y);
    stim_row_t r;
    r.op = op; r.x = x; r.y = y; r.has_fixed = 0; r.fixed = '0;
    rows = {rows, r};
  endtask

  task automatic add_fixed(logic [1:0] op, pair_t f);
    stim_row_t r;
    r.op = op; r.x = 16'hFFFF; r.y = 16'hFFFF; r.has_fixed = 1; r.fixed = f;
    rows = {rows, r};
  endtask

  initial begin
    pair_t got;
    // empty start after reset
    add_fixed(OP_START, '{i: 0, j: 0, total: 0, status: STAT_EMPTY, last: 1});
    // only P loaded: still empty
    add_row(OP_LOAD_P, 16'h1234, 16'h4321);
    add_fixed(OP_START, '{i: 0, j: 0, total: 0, status: STAT_EMPTY, last: 1});
    // opposite corners: the largest distance, both differences at their widest
    add_row(OP_LOAD_P, 16'h8000, 16'h8000);
    add_row(OP_LOAD_Q, 16'h7FFF, 16'h7FFF);
    add_fixed(OP_START, '{i: 0, j: 0, total: 23'd92680, status: STAT_OK, last: 1});
    add_row(OP_UNUSED, 16'h0000, 16'h0000);
    add_row(OP_LOAD_P, 16'h7FFF, 16'h8000);
    add_row(OP_LOAD_P, 16'h0000, 16'h0000);
    add_row(OP_LOAD_P, 16'h8000, 16'h7FFF);
    add_row(OP_LOAD_Q, 16'h0000, 16'h0000);
    add_row(OP_LOAD_Q, 16'h0000, 16'h0000);
    add_row(OP_START, 16'h0000, 16'h0000);
    // equal points everywhere: ties go up first
    for (int k = 0; k < 3; k++) add_row(OP_LOAD_P, 16'h0100, 16'h0100);
    for (int k = 0; k < 3; k++) add_row(OP_LOAD_Q, 16'h0100, 16'h0100);
    add_row(OP_START, 16'h0000, 16'h0000);

    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].has_fixed) begin
        release_input();
        while (path_q.size() != 0) @(posedge clk);
        send_item(rows[k].op, rows[k].x, rows[k].y);
        got = path_q[0];
        if (got !== rows[k].fixed) begin
          $error("directed row %0d expected %h predicted %h", k, rows[k].fixed, got);
          errors++;
        end
      end else begin
        send_item(rows[k].op, rows[k].x, rows[k].y);
      end
    end
    wait_drained();

    // full curves with overflow, sender pauses until drained
    for (int k = 0; k < NPTS + 2; k++) send_item(OP_LOAD_P, 16'($urandom), 16'($urandom));
    for (int k = 0; k < NPTS; k++) send_item(OP_LOAD_Q, 16'($urandom), 16'($urandom));
    send_item(OP_START, 0, 0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 82; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 82; end
        default: begin send_idle = 18; recv_idle = 18; end
      endcase
      for (int s = 0; s < 6; s++) begin
        random_curves($urandom_range(5, 1), $urandom_range(5, 1), $urandom_range(3) == 0);
        if ($urandom_range(9) == 0) send_item(OP_START, 0, 0);
      end
      if (phase == 2) begin
        // hold results while loads pile up behind a run
        fork
          begin
            long_hold = 1;
            repeat (3000) @(posedge clk);
            long_hold = 0;
          end
          begin
            random_curves(4, 4, 0);
            for (int k = 0; k < 10; k++)
              send_item(OP_LOAD_P, 16'($urandom), 16'($urandom));
          end
        join
        send_item(OP_LOAD_Q, 0, 0);
        send_item(OP_START, 0, 0);
      end
      wait_drained();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) $display("dtw_curve_alignment regression: pass");
    else $display("dtw_curve_alignment regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("dtw_curve_alignment regression: fail");
    $finish;
  end

endmodule
